// ===== rtl/sm83_pkg.sv =====
// Shared types and operation codes for the SM83 ALU block.
package sm83_pkg;

   typedef enum logic [4:0] {
      OP_ADD    = 5'd0,
      OP_ADC    = 5'd1,
      OP_SUB    = 5'd2,
      OP_SBC    = 5'd3,
      OP_AND    = 5'd4,
      OP_XOR    = 5'd5,
      OP_OR     = 5'd6,
      OP_CP     = 5'd7,
      OP_INC    = 5'd8,
      OP_DEC    = 5'd9,
      OP_DAA    = 5'd10,
      OP_CPL    = 5'd11,
      OP_SCF    = 5'd12,
      OP_CCF    = 5'd13,
      OP_RLCA   = 5'd14,
      OP_RLA    = 5'd15,
      OP_RRCA   = 5'd16,
      OP_RRA    = 5'd17,
      OP_RLC    = 5'd18,
      OP_RL     = 5'd19,
      OP_RRC    = 5'd20,
      OP_RR     = 5'd21,
      OP_SLA    = 5'd22,
      OP_SRA    = 5'd23,
      OP_SRL    = 5'd24,
      OP_SWAP   = 5'd25,
      OP_BIT    = 5'd26,
      OP_RES    = 5'd27,
      OP_SET    = 5'd28,
      OP_ADD16  = 5'd29,
      OP_ADDSP  = 5'd30
   } op_type;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [4:0]  op;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
      flags_type   flags_in;
   } alu_req_type;

   typedef struct packed {
      logic [15:0] value_out;
      flags_type   flags_out;
      logic        writes_value;
   } alu_rsp_type;

endpackage

// ===== rtl/sm83_alu.sv =====
// Combinational SM83 ALU: one operation, value and new Z N H C flags.
module sm83_alu
   import sm83_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic        cin;
   logic        use_c;
   logic [8:0]  sum9;
   logic [4:0]  hsum5;
   logic [8:0]  dif9;
   logic [4:0]  hdif5;
   logic [7:0]  daa_r;
   logic        daa_c;
   logic [7:0]  sh_v;
   logic        sh_c;
   logic [7:0]  bit_mask;
   logic [16:0] sum17;
   logic [12:0] sum13;
   logic [15:0] sp_sum;
   logic [8:0]  sp_lo9;
   logic [4:0]  sp_h5;
   logic [7:0]  v8;
   flags_type   fi;

   assign a   = req.operand_a[7:0];
   assign b   = req.operand_b[7:0];
   assign fi  = req.flags_in;
   assign cin = fi.c;
   assign use_c = ((req.op == OP_ADC) || (req.op == OP_SBC)) ? cin : 1'b0;

   assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, use_c};
   assign hsum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_c};
   // top bit is the borrow
   assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, use_c};
   assign hdif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_c};

   assign bit_mask = 8'd1 << req.bit_index;

   assign sum17  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
   assign sum13  = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
   assign sp_sum = req.operand_a + {{8{b[7]}}, b};
   assign sp_lo9 = {1'b0, req.operand_a[7:0]} + {1'b0, b};
   assign sp_h5  = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};

   // decimal adjust, low byte arithmetic is enough
   always_comb begin
      daa_r = a;
      daa_c = cin;
      if (!fi.n) begin
         if (cin || (a > 8'h99)) begin
            daa_r = daa_r + 8'h60;
            daa_c = 1'b1;
         end
         if (fi.h || (daa_r[3:0] > 4'd9)) begin
            daa_r = daa_r + 8'h06;
         end
      end else begin
         if (cin) begin
            daa_r = daa_r - 8'h60;
         end
         if (fi.h) begin
            daa_r = daa_r - 8'h06;
         end
      end
   end

   // rotates, shifts and nibble swap, accumulator forms share the prefixed ones
   always_comb begin
      unique case (req.op)
         OP_RLCA, OP_RLC: begin
            sh_c = a[7];
            sh_v = {a[6:0], a[7]};
         end
         OP_RLA, OP_RL: begin
            sh_c = a[7];
            sh_v = {a[6:0], cin};
         end
         OP_RRCA, OP_RRC: begin
            sh_c = a[0];
            sh_v = {a[0], a[7:1]};
         end
         OP_RRA, OP_RR: begin
            sh_c = a[0];
            sh_v = {cin, a[7:1]};
         end
         OP_SLA: begin
            sh_c = a[7];
            sh_v = {a[6:0], 1'b0};
         end
         OP_SRA: begin
            sh_c = a[0];
            sh_v = {a[7], a[7:1]};
         end
         OP_SRL: begin
            sh_c = a[0];
            sh_v = {1'b0, a[7:1]};
         end
         default: begin
            sh_c = 1'b0;
            sh_v = {a[3:0], a[7:4]};
         end
      endcase
   end

   always_comb begin
      v8                = 8'd0;
      rsp.value_out     = 16'd0;
      rsp.flags_out     = fi;
      rsp.writes_value  = 1'b1;
      unique case (req.op)
         OP_ADD, OP_ADC: begin
            v8 = sum9[7:0];
            rsp.flags_out = '{z: (v8 == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            v8 = (req.op == OP_CP) ? 8'd0 : dif9[7:0];
            rsp.writes_value = (req.op != OP_CP);
            rsp.flags_out = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
         end
         OP_AND: begin
            v8 = a & b;
            rsp.flags_out = '{z: (v8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         OP_XOR, OP_OR: begin
            v8 = (req.op == OP_XOR) ? (a ^ b) : (a | b);
            rsp.flags_out = '{z: (v8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_INC: begin
            v8 = a + 8'd1;
            rsp.flags_out = '{z: (v8 == 8'd0), n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
         end
         OP_DEC: begin
            v8 = a - 8'd1;
            rsp.flags_out = '{z: (v8 == 8'd0), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
         end
         OP_DAA: begin
            v8 = daa_r;
            rsp.flags_out = '{z: (v8 == 8'd0), n: fi.n, h: 1'b0, c: daa_c};
         end
         OP_CPL: begin
            v8 = ~a;
            rsp.flags_out = '{z: fi.z, n: 1'b1, h: 1'b1, c: cin};
         end
         OP_SCF: begin
            rsp.writes_value = 1'b0;
            rsp.flags_out = '{z: fi.z, n: 1'b0, h: 1'b0, c: 1'b1};
         end
         OP_CCF: begin
            rsp.writes_value = 1'b0;
            rsp.flags_out = '{z: fi.z, n: 1'b0, h: 1'b0, c: ~cin};
         end
         OP_RLCA, OP_RLA, OP_RRCA, OP_RRA: begin
            v8 = sh_v;
            rsp.flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: sh_c};
         end
         OP_RLC, OP_RL, OP_RRC, OP_RR, OP_SLA, OP_SRA, OP_SRL, OP_SWAP: begin
            v8 = sh_v;
            rsp.flags_out = '{z: (v8 == 8'd0), n: 1'b0, h: 1'b0, c: sh_c};
         end
         OP_BIT: begin
            rsp.writes_value = 1'b0;
            rsp.flags_out = '{z: ((a & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: cin};
         end
         OP_RES: begin
            v8 = a & ~bit_mask;
         end
         OP_SET: begin
            v8 = a | bit_mask;
         end
         OP_ADD16: begin
         end
         OP_ADDSP: begin
         end
         default: begin
            rsp.writes_value = 1'b0;
         end
      endcase

      if (req.op == OP_ADD16) begin
         rsp.value_out = sum17[15:0];
         rsp.flags_out = '{z: fi.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      end else if (req.op == OP_ADDSP) begin
         rsp.value_out = sp_sum;
         rsp.flags_out = '{z: 1'b0, n: 1'b0, h: sp_h5[4], c: sp_lo9[8]};
      end else begin
         rsp.value_out = {8'd0, v8};
      end
   end

endmodule

// ===== rtl/sm83_alu_with_flags_top.sv =====
// Top level of the SM83 ALU: input register, ALU, result register.
//
//   channel   direction  payload        handshake
//   req_      in         alu_req_type   req_valid / req_stall
//   rsp_      out        alu_rsp_type   rsp_valid / rsp_stall
//
// An accepted request beat passes through the input register, then the result
// register, before its response beat. One beat per cycle while rsp_stall is low.
// Reset (synchronous) clears both valid bits; payload registers are not reset.
// rsp_stall backs up through both stages; req_stall rises only when the input
// register holds a beat that cannot move into a stalled result register.
module sm83_alu_with_flags_top
   import sm83_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  alu_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output alu_rsp_type rsp_data
);

   logic        in_valid_ff;
   logic        in_valid_in;
   alu_req_type in_data_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   alu_rsp_type out_data_ff;
   alu_rsp_type alu_rsp;
   logic        out_load;
   logic        in_load;

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   assign in_valid_in  = in_load ? 1'b1 : (in_valid_ff && !out_load);
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   sm83_alu u_alu (
      .req (in_data_ff),
      .rsp (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (out_load && in_valid_ff) begin
         out_data_ff <= alu_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
